FILE: src/esc_pkg.sv
// Shared types, constants, stage map and helpers for the sensor compensation core.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

   localparam int unsigned RAW_PRESS_W = 20;
   localparam int unsigned RAW_TEMP_W  = 20;
   localparam int unsigned RAW_HUM_W   = 16;
   localparam int unsigned HUM_OUT_W   = 17;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;

   // Pipeline stage map (register stage numbers, first stage is 1)
   localparam int unsigned S_TFINE    = 4;
   localparam int unsigned S_TEMP     = 5;
   localparam int unsigned S_HUM      = 12;
   localparam int unsigned S_A        = 5;
   localparam int unsigned S_M1       = 6;
   localparam int unsigned S_M2       = 8;
   localparam int unsigned S_B        = 10;
   localparam int unsigned S_X        = 11;
   localparam int unsigned S_M3       = 12;
   localparam int unsigned S_ABS      = 14;
   localparam int unsigned DIV_BITS   = 2;
   localparam int unsigned DIV_STAGES = 64 / DIV_BITS;
   localparam int unsigned S_DIV      = S_ABS + 1;
   localparam int unsigned S_NEG      = S_ABS + DIV_STAGES + 1;
   localparam int unsigned S_M4       = S_NEG + 1;
   localparam int unsigned S_M5       = S_M4 + 2;
   localparam int unsigned S_SUM      = S_M5 + 2;
   localparam int unsigned DEPTH      = S_SUM + 1;

   // Compensation constants
   localparam logic [63:0] P_OFFSET  = 64'd128000;
   localparam logic [63:0] P_SCALE   = 64'd3125;
   localparam logic [63:0] P_BASE    = 64'd1048576;
   localparam logic [63:0] P_HALF    = 64'h0000_8000_0000_0000;
   localparam logic [31:0] T_ROUND   = 32'd128;
   localparam logic [31:0] H_OFFSET  = 32'd76800;
   localparam logic [31:0] H_MAX     = 32'd419430400;
   localparam logic [31:0] H_ROUND   = 32'd16384;
   localparam logic [31:0] H_BIAS    = 32'd2097152;
   localparam logic [31:0] H_ROUND2  = 32'd8192;
   localparam logic [31:0] H_UNITY   = 32'd32768;
   localparam logic [HUM_OUT_W-1:0] HUM_OUT_MAX = 17'd102400;

   typedef logic [DEPTH:1] stage_en_type;

   typedef struct packed {
      logic [47:0] temp;
      logic [63:0] press_lo;
      logic [63:0] press_hi;
      logic [47:0] mixed;
      logic [31:0] hum;
   } cal_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAL_TEMP     = 0,
      CSR_CAL_PRESS_LO = 1,
      CSR_CAL_PRESS_HI = 2,
      CSR_CAL_MIXED    = 3,
      CSR_CAL_HUM      = 4
   } csr_index_type;

   function automatic logic [63:0] sx16_64(logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx16_32(logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sx8_32(logic [7:0] v);
      return {{24{v[7]}}, v};
   endfunction

endpackage
`default_nettype wire

FILE: src/esc_req_if.sv
// Request channel: one raw reading with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface esc_req_if import esc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [RAW_PRESS_W-1:0] raw_pressure;
   logic [RAW_TEMP_W-1:0]  raw_temperature;
   logic [RAW_HUM_W-1:0]   raw_humidity;

   modport source (output valid, raw_pressure, raw_temperature, raw_humidity, input ready);
   modport sink (input valid, raw_pressure, raw_temperature, raw_humidity, output ready);
endinterface
`default_nettype wire

FILE: src/esc_rsp_if.sv
// Response channel: compensated result with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface esc_rsp_if import esc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic signed [31:0]   temperature_centi;
   logic [31:0]          pressure_q24_8;
   logic [HUM_OUT_W-1:0] humidity_q22_10;
   logic                 read_error;

   modport source (output valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                   read_error, input ready);
   modport sink (input valid, temperature_centi, pressure_q24_8, humidity_q22_10,
                 read_error, output ready);
endinterface
`default_nettype wire

FILE: src/esc_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits, built from 32x32 partials.
`timescale 1ns / 1ps
`default_nettype none
module esc_mul64 (
   input  wire logic        clock,
   input  wire logic [1:0]  en,
   input  wire logic [63:0] x,
   input  wire logic [63:0] y,
   output logic      [63:0] p
);
   logic [63:0] ll_ff, ll_in;
   logic [31:0] hl_ff, hl_in;
   logic [31:0] lh_ff, lh_in;
   logic [63:0] p_ff, p_in;

   always_comb begin
      ll_in = {32'd0, x[31:0]} * {32'd0, y[31:0]};
      hl_in = x[63:32] * y[31:0];
      lh_in = x[31:0] * y[63:32];
      // high x high only lands above bit 63
      p_in  = ll_ff + {hl_ff + lh_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
      end
      if (en[1]) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;
endmodule
`default_nettype wire

FILE: src/esc_div.sv
// Pipelined restoring divider, 64-bit dividend by 31-bit divisor, two bits per stage.
`timescale 1ns / 1ps
`default_nettype none
module esc_div import esc_pkg::*; (
   input  wire logic         clock,
   input  wire stage_en_type en,
   input  wire logic [63:0]  un,
   input  wire logic [30:0]  ud,
   output logic      [63:0]  quot
);
   logic [63:0] nq_ff [DIV_STAGES];
   logic [63:0] nq_in [DIV_STAGES];
   logic [31:0] rem_ff [DIV_STAGES];
   logic [31:0] rem_in [DIV_STAGES];
   logic [30:0] ud_ff [DIV_STAGES];
   logic [30:0] ud_in [DIV_STAGES];

   always_comb begin
      logic [63:0] nq;
      logic [31:0] rem;
      logic [31:0] trial;
      logic [30:0] dv;
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (j == 0) begin
            nq  = un;
            rem = '0;
            dv  = ud;
         end else begin
            nq  = nq_ff[j-1];
            rem = rem_ff[j-1];
            dv  = ud_ff[j-1];
         end
         // dividend bits leave at the top, quotient bits enter at the bottom
         for (int b = 0; b < DIV_BITS; b++) begin
            trial = {rem[30:0], nq[63]};
            nq    = {nq[62:0], 1'b0};
            if (trial >= {1'b0, dv}) begin
               rem   = trial - {1'b0, dv};
               nq[0] = 1'b1;
            end else begin
               rem = trial;
            end
         end
         nq_in[j]  = nq;
         rem_in[j] = rem;
         ud_in[j]  = dv;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         if (en[S_DIV + j]) begin
            nq_ff[j]  <= nq_in[j];
            rem_ff[j] <= rem_in[j];
            ud_ff[j]  <= ud_in[j];
         end
      end
   end

   assign quot = nq_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

FILE: src/esc_temp.sv
// Temperature path: fine temperature term and temperature in hundredths of a degree.
`timescale 1ns / 1ps
`default_nettype none
module esc_temp import esc_pkg::*; (
   input  wire logic                  clock,
   input  wire stage_en_type          en,
   input  wire cal_type               cal,
   input  wire logic [RAW_TEMP_W-1:0] raw_temperature,
   output logic      [31:0]           tfine,
   output logic      [31:0]           temp_centi
);
   logic [15:0] t1;
   logic [31:0] t2, t3;
   logic [31:0] u1_ff, u1_in, d_ff, d_in;
   logic [31:0] v1m_ff, v1m_in, dd_ff, dd_in;
   logic [31:0] v1_ff, v1_in, w_ff, w_in;
   logic [31:0] tfine_ff, tfine_in;
   logic [31:0] temp_ff, temp_in;

   assign t1 = cal.temp[15:0];
   assign t2 = sx16_32(cal.temp[31:16]);
   assign t3 = sx16_32(cal.temp[47:32]);

   always_comb begin
      u1_in    = 32'(raw_temperature >> 3) - {15'd0, t1, 1'b0};
      d_in     = 32'(raw_temperature >> 4) - {16'd0, t1};
      v1m_in   = u1_ff * t2;
      dd_in    = d_ff * d_ff;
      v1_in    = 32'($signed(v1m_ff) >>> 11);
      w_in     = 32'($signed(dd_ff) >>> 12) * t3;
      tfine_in = v1_ff + 32'($signed(w_ff) >>> 14);
      temp_in  = 32'($signed((tfine_ff << 2) + tfine_ff + T_ROUND) >>> 8);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u1_ff <= u1_in;
         d_ff  <= d_in;
      end
      if (en[2]) begin
         v1m_ff <= v1m_in;
         dd_ff  <= dd_in;
      end
      if (en[3]) begin
         v1_ff <= v1_in;
         w_ff  <= w_in;
      end
      if (en[S_TFINE]) begin
         tfine_ff <= tfine_in;
      end
      if (en[S_TEMP]) begin
         temp_ff <= temp_in;
      end
   end

   assign tfine      = tfine_ff;
   assign temp_centi = temp_ff;
endmodule
`default_nettype wire

FILE: src/esc_hum.sv
// Humidity path: 32-bit wrapping compensation with clamp, eight stages after t_fine.
`timescale 1ns / 1ps
`default_nettype none
module esc_hum import esc_pkg::*; (
   input  wire logic                 clock,
   input  wire stage_en_type         en,
   input  wire cal_type              cal,
   input  wire logic [RAW_HUM_W-1:0] raw_humidity,
   input  wire logic [31:0]          tfine,
   output logic      [HUM_OUT_W-1:0] humidity
);
   logic [7:0]  h1, h3;
   logic [31:0] h2, h6;
   logic [11:0] h4, h5;
   logic [RAW_HUM_W-1:0] hraw_ff [1:S_TFINE+1];
   logic [31:0] v;
   logic [31:0] m5_ff, m5_in, m6_ff, m6_in, m3_ff, m3_in;
   logic [31:0] x6_ff, x6_in, ya_ff, ya_in, yb_ff, yb_in;
   logic [31:0] y1_ff, y1_in, x7_ff;
   logic [31:0] y3m_ff, y3m_in, x8_ff;
   logic [31:0] xy9_ff, xy9_in;
   logic [31:0] ss_ff, ss_in, xy10_ff, s10;
   logic [31:0] t_ff, t_in, xy11_ff;
   logic [31:0] vv, vc;
   logic [HUM_OUT_W-1:0] hum_ff, hum_in;

   assign h1 = cal.mixed[23:16];
   assign h2 = sx16_32(cal.mixed[39:24]);
   assign h3 = cal.mixed[47:40];
   assign h4 = cal.hum[11:0];
   assign h5 = cal.hum[23:12];
   assign h6 = sx8_32(cal.hum[31:24]);

   always_comb begin
      v      = tfine - H_OFFSET;
      m5_in  = {20'd0, h5} * v;
      m6_in  = v * h6;
      m3_in  = v * {24'd0, h3};
      x6_in  = 32'($signed(({16'd0, hraw_ff[S_TFINE+1]} << 14) - ({20'd0, h4} << 20)
                           - m5_ff + H_ROUND) >>> 15);
      ya_in  = 32'($signed(m6_ff) >>> 10);
      yb_in  = 32'($signed(m3_ff) >>> 11) + H_UNITY;
      y1_in  = ya_ff * yb_ff;
      y3m_in = (32'($signed(y1_ff) >>> 10) + H_BIAS) * h2;
      xy9_in = x8_ff * 32'($signed(y3m_ff + H_ROUND2) >>> 14);
      s10    = 32'($signed(xy9_ff) >>> 15);
      ss_in  = s10 * s10;
      t_in   = 32'($signed(ss_ff) >>> 7) * {24'd0, h1};
      vv     = xy11_ff - 32'($signed(t_ff) >>> 4);
      if (vv[31]) begin
         vc = '0;
      end else if (vv > H_MAX) begin
         vc = H_MAX;
      end else begin
         vc = vv;
      end
      hum_in = vc[HUM_OUT_W+11:12];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hraw_ff[1] <= raw_humidity;
      end
      for (int k = 2; k <= S_TFINE + 1; k++) begin
         if (en[k]) begin
            hraw_ff[k] <= hraw_ff[k-1];
         end
      end
      if (en[S_TFINE+1]) begin
         m5_ff <= m5_in;
         m6_ff <= m6_in;
         m3_ff <= m3_in;
      end
      if (en[S_TFINE+2]) begin
         x6_ff <= x6_in;
         ya_ff <= ya_in;
         yb_ff <= yb_in;
      end
      if (en[S_TFINE+3]) begin
         y1_ff <= y1_in;
         x7_ff <= x6_ff;
      end
      if (en[S_TFINE+4]) begin
         y3m_ff <= y3m_in;
         x8_ff  <= x7_ff;
      end
      if (en[S_TFINE+5]) begin
         xy9_ff <= xy9_in;
      end
      if (en[S_TFINE+6]) begin
         ss_ff   <= ss_in;
         xy10_ff <= xy9_ff;
      end
      if (en[S_TFINE+7]) begin
         t_ff    <= t_in;
         xy11_ff <= xy10_ff;
      end
      if (en[S_HUM]) begin
         hum_ff <= hum_in;
      end
   end

   assign humidity = hum_ff;
endmodule
`default_nettype wire

FILE: src/esc_press.sv
// Pressure path: 64-bit wrapping polynomial, pipelined signed division and correction sum.
`timescale 1ns / 1ps
`default_nettype none
module esc_press import esc_pkg::*; (
   input  wire logic                   clock,
   input  wire stage_en_type           en,
   input  wire cal_type                cal,
   input  wire logic [RAW_PRESS_W-1:0] raw_pressure,
   input  wire logic [31:0]            tfine,
   output logic      [63:0]            sum,
   output logic                        zero_div
);
   logic [63:0] p1, p2, p3, p4, p5, p6, p8, p9;
   logic [RAW_PRESS_W-1:0] praw_ff [1:S_B];
   logic [63:0] a_ff, a_in;
   logic [63:0] a_dl_ff [S_M1:S_M1+1];
   logic [63:0] aa, b1, aa3, ap5, ap2;
   logic [63:0] b_ff, b_in, a2_ff, a2_in;
   logic [63:0] x_ff, x_in, d0_ff, d0_in;
   logic [63:0] num, den;
   logic [30:0] dv;
   logic [63:0] un_ff, un_in;
   logic [30:0] ud_ff, ud_in;
   logic        neg_in, zero_in;
   logic        neg_ff [S_ABS:S_NEG-1];
   logic        zero_ff [S_ABS:S_SUM];
   logic [63:0] quot;
   logic [63:0] pq_ff [S_NEG:S_SUM-1];
   logic [63:0] pq_in, qs, qq, c1, c2;
   logic [63:0] sum_ff, sum_in;

   assign p1 = {48'd0, cal.press_lo[15:0]};
   assign p2 = sx16_64(cal.press_lo[31:16]);
   assign p3 = sx16_64(cal.press_lo[47:32]);
   assign p4 = sx16_64(cal.press_lo[63:48]);
   assign p5 = sx16_64(cal.press_hi[15:0]);
   assign p6 = sx16_64(cal.press_hi[31:16]);
   assign p8 = sx16_64(cal.press_hi[63:48]);
   assign p9 = sx16_64(cal.mixed[15:0]);

   esc_mul64 u_mul_aa (.clock, .en({en[S_M1+1], en[S_M1]}), .x(a_ff), .y(a_ff), .p(aa));

   esc_mul64 u_mul_b1 (.clock, .en({en[S_M2+1], en[S_M2]}), .x(aa), .y(p6), .p(b1));
   esc_mul64 u_mul_a3 (.clock, .en({en[S_M2+1], en[S_M2]}), .x(aa), .y(p3), .p(aa3));
   esc_mul64 u_mul_p5 (.clock, .en({en[S_M2+1], en[S_M2]}), .x(a_dl_ff[S_M1+1]),
                       .y(p5), .p(ap5));
   esc_mul64 u_mul_p2 (.clock, .en({en[S_M2+1], en[S_M2]}), .x(a_dl_ff[S_M1+1]),
                       .y(p2), .p(ap2));

   esc_mul64 u_mul_num (.clock, .en({en[S_M3+1], en[S_M3]}), .x(x_ff), .y(P_SCALE),
                        .p(num));
   esc_mul64 u_mul_den (.clock, .en({en[S_M3+1], en[S_M3]}), .x(d0_ff), .y(p1), .p(den));

   esc_div u_div (.clock, .en, .un(un_ff), .ud(ud_ff), .quot);

   esc_mul64 u_mul_qq (.clock, .en({en[S_M4+1], en[S_M4]}), .x(qs), .y(qs), .p(qq));

   esc_mul64 u_mul_c1 (.clock, .en({en[S_M5+1], en[S_M5]}), .x(qq), .y(p9), .p(c1));
   esc_mul64 u_mul_c2 (.clock, .en({en[S_M5+1], en[S_M5]}), .x(pq_ff[S_M5-1]),
                       .y(p8), .p(c2));

   always_comb begin
      a_in    = {{32{tfine[31]}}, tfine} - P_OFFSET;
      b_in    = b1 + (ap5 << 17) + (p4 << 35);
      a2_in   = 64'($signed(aa3) >>> 8) + (ap2 << 12);
      x_in    = ((P_BASE - {{(64-RAW_PRESS_W){1'b0}}, praw_ff[S_B]}) << 31) - b_ff;
      d0_in   = P_HALF + a2_ff;
      dv      = den[63:33];
      zero_in = (dv == '0);
      neg_in  = num[63] ^ dv[30];
      un_in   = num[63] ? (64'd0 - num) : num;
      ud_in   = dv[30] ? (31'd0 - dv) : dv;
      // most negative over minus one comes back out as most negative
      pq_in   = neg_ff[S_NEG-1] ? (64'd0 - quot) : quot;
      qs      = 64'($signed(pq_ff[S_NEG]) >>> 13);
      sum_in  = pq_ff[S_SUM-1] + 64'($signed(c1) >>> 25) + 64'($signed(c2) >>> 19);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         praw_ff[1] <= raw_pressure;
      end
      for (int k = 2; k <= S_B; k++) begin
         if (en[k]) begin
            praw_ff[k] <= praw_ff[k-1];
         end
      end
      if (en[S_A]) begin
         a_ff <= a_in;
      end
      if (en[S_M1]) begin
         a_dl_ff[S_M1] <= a_ff;
      end
      if (en[S_M1+1]) begin
         a_dl_ff[S_M1+1] <= a_dl_ff[S_M1];
      end
      if (en[S_B]) begin
         b_ff  <= b_in;
         a2_ff <= a2_in;
      end
      if (en[S_X]) begin
         x_ff  <= x_in;
         d0_ff <= d0_in;
      end
      if (en[S_ABS]) begin
         un_ff            <= un_in;
         ud_ff            <= ud_in;
         neg_ff[S_ABS]    <= neg_in;
         zero_ff[S_ABS]   <= zero_in;
      end
      for (int k = S_ABS + 1; k < S_NEG; k++) begin
         if (en[k]) begin
            neg_ff[k] <= neg_ff[k-1];
         end
      end
      for (int k = S_ABS + 1; k <= S_SUM; k++) begin
         if (en[k]) begin
            zero_ff[k] <= zero_ff[k-1];
         end
      end
      if (en[S_NEG]) begin
         pq_ff[S_NEG] <= pq_in;
      end
      for (int k = S_NEG + 1; k < S_SUM; k++) begin
         if (en[k]) begin
            pq_ff[k] <= pq_ff[k-1];
         end
      end
      if (en[S_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   assign sum      = sum_ff;
   assign zero_div = zero_ff[S_SUM];
endmodule
`default_nettype wire

FILE: src/env_sensor_compensation_core.sv
// Top level of the temperature, pressure and humidity compensation pipeline.
//
//   channel  | dir | handshake          | contents
//   req_chan | in  | valid/ready        | raw_pressure, raw_temperature, raw_humidity
//   rsp_chan | out | valid/ready        | temperature_centi, pressure_q24_8,
//            |     |                    | humidity_q22_10, read_error
//   csr_*    | in  | csr_we, no stall   | csr_index selects a calibration word
//
// One request per cycle while the pipeline is not stalled, through 53 register stages;
// the 32-stage divider (two quotient bits per stage) sets most of that depth.
// Synchronous reset clears calibration words and all stage valid bits.
// A stalled response holds every stage in front of the output register while the stage
// feeding it is full; the pipeline keeps taking requests while that stage is empty.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_core import esc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   esc_req_if.sink                     req_chan,
   esc_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);
   cal_type      cal_ff, cal_in;
   logic [DEPTH:1] vld_ff, vld_in;
   stage_en_type en;
   logic         out_en, adv;
   logic         err_new;
   logic         err_ff [1:DEPTH-1];
   logic [31:0]  tfine, temp_centi;
   logic [31:0]  temp_ff [S_TEMP+1:DEPTH-1];
   logic [HUM_OUT_W-1:0] humidity;
   logic [HUM_OUT_W-1:0] hum_ff [S_HUM+1:DEPTH-1];
   logic [63:0]  psum;
   logic         zero_div;
   logic [15:0]  p7;
   logic [31:0]  temp_out_ff, temp_out_in;
   logic [31:0]  press_out_ff, press_out_in;
   logic [HUM_OUT_W-1:0] hum_out_ff, hum_out_in;
   logic         err_out_ff, err_out_in;

   // calibration writes
   always_comb begin
      cal_in = cal_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CAL_TEMP:     cal_in.temp     = csr_wdata[47:0];
            CSR_CAL_PRESS_LO: cal_in.press_lo = csr_wdata;
            CSR_CAL_PRESS_HI: cal_in.press_hi = csr_wdata;
            CSR_CAL_MIXED:    cal_in.mixed    = csr_wdata[47:0];
            CSR_CAL_HUM:      cal_in.hum      = csr_wdata[31:0];
            default:          cal_in = cal_ff;
         endcase
      end
   end

   // stage enables: output register, then everything in front of it
   always_comb begin
      out_en = !vld_ff[DEPTH] || rsp_chan.ready;
      adv    = out_en || !vld_ff[DEPTH-1];
      en     = {out_en, {(DEPTH-1){adv}}};
      vld_in = vld_ff;
      if (en[1]) begin
         vld_in[1] = req_chan.valid;
      end
      for (int k = 2; k <= DEPTH; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
         vld_ff <= '0;
      end else begin
         cal_ff <= cal_in;
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = adv;
   assign err_new = (req_chan.raw_pressure == '0) && (req_chan.raw_temperature == '0)
                    && (req_chan.raw_humidity == '0);

   esc_temp u_temp (
      .clock, .en, .cal(cal_ff),
      .raw_temperature(req_chan.raw_temperature),
      .tfine, .temp_centi
   );

   esc_hum u_hum (
      .clock, .en, .cal(cal_ff),
      .raw_humidity(req_chan.raw_humidity),
      .tfine, .humidity
   );

   esc_press u_press (
      .clock, .en, .cal(cal_ff),
      .raw_pressure(req_chan.raw_pressure),
      .tfine, .sum(psum), .zero_div
   );

   always_ff @(posedge clock) begin
      if (en[1]) begin
         err_ff[1] <= err_new;
      end
      for (int k = 2; k < DEPTH; k++) begin
         if (en[k]) begin
            err_ff[k] <= err_ff[k-1];
         end
      end
      if (en[S_TEMP+1]) begin
         temp_ff[S_TEMP+1] <= temp_centi;
      end
      for (int k = S_TEMP + 2; k < DEPTH; k++) begin
         if (en[k]) begin
            temp_ff[k] <= temp_ff[k-1];
         end
      end
      if (en[S_HUM+1]) begin
         hum_ff[S_HUM+1] <= humidity;
      end
      for (int k = S_HUM + 2; k < DEPTH; k++) begin
         if (en[k]) begin
            hum_ff[k] <= hum_ff[k-1];
         end
      end
      if (en[DEPTH]) begin
         temp_out_ff  <= temp_out_in;
         press_out_ff <= press_out_in;
         hum_out_ff   <= hum_out_in;
         err_out_ff   <= err_out_in;
      end
   end

   // only the low 32 bits of the final shift-and-add are kept
   assign p7 = cal_ff.press_hi[47:32];

   always_comb begin
      err_out_in  = err_ff[DEPTH-1];
      temp_out_in = err_out_in ? '0 : temp_ff[DEPTH-1];
      hum_out_in  = err_out_in ? '0 : hum_ff[DEPTH-1];
      if (err_out_in || zero_div) begin
         press_out_in = '0;
      end else begin
         press_out_in = psum[39:8] + {{12{p7[15]}}, p7, 4'd0};
      end
   end

   assign rsp_chan.valid             = vld_ff[DEPTH];
   assign rsp_chan.temperature_centi = temp_out_ff;
   assign rsp_chan.pressure_q24_8    = press_out_ff;
   assign rsp_chan.humidity_q22_10   = hum_out_ff;
   assign rsp_chan.read_error        = err_out_ff;

   a_err_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.read_error |->
         rsp_chan.temperature_centi == '0 && rsp_chan.pressure_q24_8 == '0
         && rsp_chan.humidity_q22_10 == '0)
      else $error("error response carries nonzero fields");

   a_hum_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.humidity_q22_10 <= HUM_OUT_MAX)
      else $error("humidity above clamp");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DEPTH] && vld_ff[DEPTH-1] && !rsp_chan.ready |-> !req_chan.ready)
      else $error("pipeline advances into a stalled output");

   a_drain_only: assert property (@(posedge clock) disable iff (reset)
      $fell(vld_ff[DEPTH]) |-> $past(rsp_chan.ready))
      else $error("response dropped without handshake");
endmodule
`default_nettype wire
